[rtl/c2p_pkg.sv]
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, constants and the arctangent table of the Cartesian-to-polar
// index mapper.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned MAX_DIM_DEF   = 4096;

  localparam int unsigned DIM_W        = 13;
  localparam int unsigned RQ_BITS      = 30;
  localparam int unsigned DIV_STEPS    = 2 * RQ_BITS;
  localparam int unsigned SQRT_STEPS   = RQ_BITS + 1;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned VEC_SCALE    = 20;
  localparam int unsigned VEC_W        = 48;
  localparam int unsigned IDX_W        = 20;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

  // register indexes of the configuration port
  localparam logic [7:0] REG_OUT_WIDTH    = 8'd0;
  localparam logic [7:0] REG_OUT_HEIGHT   = 8'd1;
  localparam logic [7:0] REG_ANGLE_COUNT  = 8'd2;
  localparam logic [7:0] REG_RADIUS_COUNT = 8'd3;

  // atan(2^-i) as a Q0.32 fraction of a full turn
  localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } in_t;

  typedef struct packed {
    logic             inside_res;
    logic [IDX_W-1:0] angle_index;
    logic [IDX_W-1:0] radius_index;
  } out_t;

  // effective (clamped) sizes
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] ac;
    logic [DIM_W-1:0] rc;
  } dims_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [25:0] px;
    logic signed [25:0] py;
    logic        [47:0] rem0;
    logic               q0;
    logic        [47:0] d2;
    logic               in_circle;
  } work_t;

endpackage

[rtl/c2p_queue.sv]
// ----------------------------------------------------------------------------
// c2p_queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module c2p_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  c2p_pkg::work_t   push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output c2p_pkg::work_t   pop_data_o
);

  localparam int unsigned PTR_W = $clog2(c2p_pkg::QUEUE_DEPTH);

  c2p_pkg::work_t mem_q [0:c2p_pkg::QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (PTR_W+1)'(c2p_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    count_d  = count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(c2p_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

[rtl/c2p_front.sv]
// ----------------------------------------------------------------------------
// c2p_front
// Accepts pixel coordinates, forms the scaled vector, its squared length and
// the inside test, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module c2p_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  c2p_pkg::dims_t  dims_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  c2p_pkg::in_t    in_data_i,
  output logic            push_o,
  output c2p_pkg::work_t  push_data_o,
  input  logic            full_i
);

  logic               en;
  logic               v1_q, v2_q, v3_q;
  logic signed [25:0] px1_q, py1_q, px1_d, py1_d;
  logic signed [25:0] pxc_q, pyc_q;
  logic        [23:0] d1_q, d1_d;
  logic        [49:0] px2_q, py2_q;
  logic        [47:0] d2_q;
  c2p_pkg::work_t     w3_q, w3_d;

  logic signed [14:0] xs, ys;
  logic        [12:0] dx, dy;
  logic signed [28:0] pxw, pyw;
  logic signed [51:0] pxs, pys;
  logic        [50:0] s;

  // hold every stage while the last one cannot push
  assign en         = !v3_q || !full_i;
  assign in_stall_o = !en;
  assign push_o     = v3_q && en;
  assign push_data_o = w3_q;

  always_comb begin
    dx    = dims_i.w - 13'd1;
    dy    = dims_i.h - 13'd1;
    xs    = $signed({2'b0, in_data_i.column, 1'b0}) - $signed({2'b0, dims_i.w}) - 15'sd1;
    ys    = $signed({2'b0, in_data_i.row, 1'b0}) - $signed({2'b0, dims_i.h}) - 15'sd1;
    pxw   = xs * $signed({1'b0, dy});
    pyw   = ys * $signed({1'b0, dx});
    px1_d = pxw[25:0];
    py1_d = pyw[25:0];
    d1_d  = 24'(dx[11:0] * dy[11:0]);
  end

  always_comb begin
    s              = {1'b0, px2_q} + {1'b0, py2_q};
    w3_d.px        = pxc_q;
    w3_d.py        = pyc_q;
    w3_d.d2        = d2_q;
    w3_d.in_circle = (s <= {3'b0, d2_q});
    w3_d.q0        = (s == {3'b0, d2_q});
    w3_d.rem0      = w3_d.q0 ? 48'd0 : s[47:0];
  end

  assign pxs = px1_q * px1_q;
  assign pys = py1_q * py1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= px1_d;
      py1_q <= py1_d;
      d1_q  <= d1_d;
      pxc_q <= px1_q;
      pyc_q <= py1_q;
      px2_q <= pxs[49:0];
      py2_q <= pys[49:0];
      d2_q  <= 48'(d1_q * d1_q);
      w3_q  <= w3_d;
    end
  end

endmodule

[rtl/c2p_back.sv]
// ----------------------------------------------------------------------------
// c2p_back
// Pipeline that carries out one item per stage: restoring division of the
// squared radius, CORDIC vectoring for the angle, integer square root, index
// scaling and saturation, with an output register.
// ----------------------------------------------------------------------------
module c2p_back #(
  parameter int unsigned FRAC_BITS = c2p_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  c2p_pkg::dims_t  dims_i,
  input  logic            empty_i,
  input  c2p_pkg::work_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output c2p_pkg::out_t   out_data_o
);

  localparam int unsigned ND = c2p_pkg::DIV_STEPS;
  localparam int unsigned NS = c2p_pkg::SQRT_STEPS;
  localparam int unsigned NC = c2p_pkg::CORDIC_STEPS;
  localparam int unsigned NT = ND + NS;
  localparam int unsigned VW = c2p_pkg::VEC_W;

  logic en;

  logic        valid_q  [0:NT];
  logic        inside_q [0:NT];
  logic [31:0] acc_q    [0:NT];

  logic [47:0] rem_q [0:ND];
  logic [60:0] quo_q [0:ND];
  logic [47:0] d2_q  [0:ND];

  logic signed [VW-1:0] vx_q [0:NC];
  logic signed [VW-1:0] vy_q [0:NC];

  logic [61:0] n_q   [1:NS];
  logic [61:0] res_q [1:NS];

  logic        mv_q, min_q;
  logic [43:0] ri_raw_q;
  logic [44:0] ai_raw_q;

  logic          ov_q;
  c2p_pkg::out_t od_q, od_d;

  // whole pipeline advances unless the result register is held
  assign en          = !(ov_q && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // stage zero: load from the queue, set up the CORDIC vector
  logic signed [VW-1:0] vx0_d, vy0_d, pxe, pye;
  logic        [31:0]   acc0_d;

  always_comb begin
    pxe = VW'(head_i.px) <<< c2p_pkg::VEC_SCALE;
    pye = VW'(head_i.py) <<< c2p_pkg::VEC_SCALE;
    priority if (head_i.px == '0) begin
      vx0_d = '0;
      vy0_d = '0;
      if (head_i.py == '0) begin
        acc0_d = '0;
      end else if (head_i.py > 0) begin
        acc0_d = c2p_pkg::TURN_QUARTER;
      end else begin
        acc0_d = c2p_pkg::TURN_3QUARTER;
      end
    end else if (head_i.px < 0) begin
      vx0_d  = -pxe;
      vy0_d  = -pye;
      acc0_d = c2p_pkg::TURN_HALF;
    end else begin
      vx0_d  = pxe;
      vy0_d  = pye;
      acc0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q[0] <= head_i.in_circle;
      acc_q[0]    <= acc0_d;
      rem_q[0]    <= head_i.rem0;
      quo_q[0]    <= {60'd0, head_i.q0};
      d2_q[0]     <= head_i.d2;
      vx_q[0]     <= vx0_d;
      vy_q[0]     <= vy0_d;
    end
  end

  // control and common payload of every stage
  for (genvar j = 1; j <= NT; j++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en) begin
        valid_q[j] <= valid_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        inside_q[j] <= inside_q[j-1];
      end
    end
  end

  // division: one quotient bit per stage
  for (genvar j = 1; j <= ND; j++) begin : g_div
    logic [48:0] sh;
    logic [47:0] rem_d;
    logic [60:0] quo_d;
    always_comb begin
      sh = {rem_q[j-1], 1'b0};
      if (sh >= {1'b0, d2_q[j-1]}) begin
        rem_d = 48'(sh - {1'b0, d2_q[j-1]});
        quo_d = {quo_q[j-1][59:0], 1'b1};
      end else begin
        rem_d = sh[47:0];
        quo_d = {quo_q[j-1][59:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        d2_q[j]  <= d2_q[j-1];
      end
    end
  end

  // CORDIC vectoring alongside the first division stages
  for (genvar j = 1; j <= NT; j++) begin : g_ang
    if (j <= NC) begin : g_rot
      logic signed [VW-1:0] sx, sy, vx_d, vy_d;
      logic        [31:0]   acc_d;
      always_comb begin
        sx = vx_q[j-1] >>> (j-1);
        sy = vy_q[j-1] >>> (j-1);
        priority if (vy_q[j-1] > 0) begin
          vx_d  = vx_q[j-1] + sy;
          vy_d  = vy_q[j-1] - sx;
          acc_d = acc_q[j-1] + c2p_pkg::ATAN_TURNS[j-1];
        end else if (vy_q[j-1] < 0) begin
          vx_d  = vx_q[j-1] - sy;
          vy_d  = vy_q[j-1] + sx;
          acc_d = acc_q[j-1] - c2p_pkg::ATAN_TURNS[j-1];
        end else begin
          vx_d  = vx_q[j-1];
          vy_d  = vy_q[j-1];
          acc_d = acc_q[j-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          vx_q[j]  <= vx_d;
          vy_q[j]  <= vy_d;
          acc_q[j] <= acc_d;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          acc_q[j] <= acc_q[j-1];
        end
      end
    end
  end

  // square root: one result bit per stage
  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (NS - k));
    logic [61:0] n_in, res_in, trial, n_d, res_d;
    always_comb begin
      if (k == 1) begin
        n_in   = {1'b0, quo_q[ND]};
        res_in = '0;
      end else begin
        n_in   = n_q[k == 1 ? 1 : k-1];
        res_in = res_q[k == 1 ? 1 : k-1];
      end
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_d   = n_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        n_q[k]   <= n_d;
        res_q[k] <= res_d;
      end
    end
  end

  // index scaling
  localparam int unsigned DIM_W_L = c2p_pkg::DIM_W;
  logic [DIM_W_L-1:0] rc_m1;
  assign rc_m1 = dims_i.rc - DIM_W_L'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      mv_q <= valid_q[NT];
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      min_q    <= inside_q[NT];
      ri_raw_q <= res_q[NS][30:0] * rc_m1;
      ai_raw_q <= acc_q[NT] * dims_i.ac;
    end
  end

  // saturate, zero outside the unit circle
  logic [43:0] ri_sh;
  logic [44:0] ai_sh;

  always_comb begin
    ri_sh = ri_raw_q >> (c2p_pkg::RQ_BITS - FRAC_BITS);
    ai_sh = ai_raw_q >> (32 - FRAC_BITS);
    od_d.inside_res   = min_q;
    od_d.radius_index = (ri_sh > 44'(c2p_pkg::IDX_MAX)) ? c2p_pkg::IDX_MAX
                                                       : ri_sh[c2p_pkg::IDX_W-1:0];
    od_d.angle_index  = (ai_sh > 45'(c2p_pkg::IDX_MAX)) ? c2p_pkg::IDX_MAX
                                                       : ai_sh[c2p_pkg::IDX_W-1:0];
    if (!min_q) begin
      od_d.radius_index = '0;
      od_d.angle_index  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q <= od_d;
    end
  end

endmodule

[rtl/cartesian_to_polar_index_mapper_core.sv]
// ----------------------------------------------------------------------------
// cartesian_to_polar_index_mapper_core
// Maps Cartesian output pixels to fractional polar sample indices.
// ----------------------------------------------------------------------------
// One pixel coordinate is accepted per clock and one result leaves per clock
// once the pipeline is full, while no stall holds it. From accept to result an
// item passes four front stages (offset and scale multiply, squares, inside
// test, queue), then a back pipeline of one load stage, 60 restoring-division
// stages (the CORDIC angle runs in the first 30 of them), 31 square-root
// stages, one index multiply stage and the result register. A four-entry
// queue between front and back lets the input keep flowing while the output
// is stalled, until it is full. Configuration is written through a valid/ready
// port that is always ready; write it only while no item is in flight.
module cartesian_to_polar_index_mapper_core #(
  parameter int unsigned FRAC_BITS = c2p_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [7:0]                  cfg_index_i,
  input  logic [c2p_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  c2p_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output c2p_pkg::out_t               out_data_o
);

  localparam int unsigned DW = c2p_pkg::DIM_W;

  logic [DW-1:0] width_q, height_q, acount_q, rcount_q;
  c2p_pkg::dims_t dims;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                              input logic [DW-1:0] lo);
    logic [DW-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (32'(v) > 32'(c2p_pkg::MAX_DIM_DEF)) begin
      r = DW'(c2p_pkg::MAX_DIM_DEF);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(512);
      height_q <= DW'(512);
      acount_q <= DW'(512);
      rcount_q <= DW'(512);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c2p_pkg::REG_OUT_WIDTH:    width_q  <= cfg_data_i;
        c2p_pkg::REG_OUT_HEIGHT:   height_q <= cfg_data_i;
        c2p_pkg::REG_ANGLE_COUNT:  acount_q <= cfg_data_i;
        c2p_pkg::REG_RADIUS_COUNT: rcount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.w  = clamp_dim(width_q,  DW'(2));
    dims.h  = clamp_dim(height_q, DW'(2));
    dims.ac = clamp_dim(acount_q, DW'(1));
    dims.rc = clamp_dim(rcount_q, DW'(2));
  end

  logic           push, full, pop, empty;
  c2p_pkg::work_t push_data, head;

  c2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  c2p_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (head)
  );

  c2p_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_res |->
      out_data_o.angle_index == '0 && out_data_o.radius_index == '0)
    else $error("outside result with nonzero index");
  a_dims_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dims.w >= DW'(2) && dims.h >= DW'(2) && dims.rc >= DW'(2) && dims.ac != '0)
    else $error("clamped size below minimum");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

[verif/tb_cartesian_to_polar_index_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_index_mapper_core
// Drives pixel coordinates through the index mapper under several image and
// polar sizes and compares each result with a bit-exact software mapper.
// Both handshakes idle at random. A watchdog catches a stuck pipeline.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_index_mapper_core;

  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 5000;

  // index past the end of the register list
  localparam logic [7:0] REG_UNMAPPED = 8'd7;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [7:0]                   cfg_index;
  logic [c2p_pkg::DIM_W-1:0]    cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  c2p_pkg::in_t                 in_data;
  logic                         out_valid;
  logic                         out_stall;
  c2p_pkg::out_t                out_data;

  logic [c2p_pkg::DIM_W-1:0] width_r, height_r, angles_r, radii_r;
  c2p_pkg::out_t             pixel_results_q [$];
  int                        error_count;
  int                        idle_cycles;
  int                        stall_left;
  bit                        quiet;

  cartesian_to_polar_index_mapper_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clamp_dim(logic [c2p_pkg::DIM_W-1:0] v, int unsigned lo);
    if (v < lo) return lo;
    if (v > c2p_pkg::MAX_DIM_DEF) return c2p_pkg::MAX_DIM_DEF;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // angle as a fraction of a full turn, Q0.32
  function automatic logic [31:0] vector_turns(longint vx, longint vy);
    logic [31:0] acc;
    longint      nx, ny;
    acc = '0;
    if (vx == 0) begin
      if (vy == 0) return '0;
      return (vy > 0) ? c2p_pkg::TURN_QUARTER : c2p_pkg::TURN_3QUARTER;
    end
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = c2p_pkg::TURN_HALF;
    end
    vx = vx <<< c2p_pkg::VEC_SCALE;
    vy = vy <<< c2p_pkg::VEC_SCALE;
    for (int i = 0; i < c2p_pkg::CORDIC_STEPS; i++) begin
      if (vy == 0) break;
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        ny  = vy - (vx >>> i);
        acc = acc + c2p_pkg::ATAN_TURNS[i];
      end else begin
        nx  = vx - (vy >>> i);
        ny  = vy + (vx >>> i);
        acc = acc - c2p_pkg::ATAN_TURNS[i];
      end
      vx = nx;
      vy = ny;
    end
    return acc;
  endfunction

  function automatic c2p_pkg::out_t map_pixel(c2p_pkg::in_t p);
    longint          w, h, dx, dy, xo, yo, px, py;
    longint unsigned ac, rc, s, d, d2, q, rem, rq, ri, ai;
    c2p_pkg::out_t   r;
    w  = clamp_dim(width_r, 2);
    h  = clamp_dim(height_r, 2);
    ac = clamp_dim(angles_r, 1);
    rc = clamp_dim(radii_r, 2);
    xo = 2 * longint'(p.column) - w - 1;
    yo = 2 * longint'(p.row) - h - 1;
    dx = w - 1;
    dy = h - 1;
    px = xo * dy;
    py = yo * dx;
    s  = px * px + py * py;
    d  = dx * dy;
    d2 = d * d;
    r  = '0;
    if (s > d2) return r;
    q   = (s == d2) ? 1 : 0;
    rem = s - q * d2;
    for (int i = 0; i < 2 * c2p_pkg::RQ_BITS; i++) begin
      rem <<= 1;
      q   <<= 1;
      if (rem >= d2) begin
        rem -= d2;
        q   |= 1;
      end
    end
    rq = int_sqrt(q);
    ri = (rq * (rc - 1)) >> (c2p_pkg::RQ_BITS - c2p_pkg::FRAC_BITS_DEF);
    if (ri > c2p_pkg::IDX_MAX) ri = c2p_pkg::IDX_MAX;
    ai = (longint'(vector_turns(px, py)) * ac) >> (32 - c2p_pkg::FRAC_BITS_DEF);
    if (ai > c2p_pkg::IDX_MAX) ai = c2p_pkg::IDX_MAX;
    r.inside_res   = 1'b1;
    r.angle_index  = ai[c2p_pkg::IDX_W-1:0];
    r.radius_index = ri[c2p_pkg::IDX_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: stall in runs of random length
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // check each result and keep the watchdog
  always @(posedge clk) begin
    c2p_pkg::out_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_results_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        want = pixel_results_q.pop_front();
        if (out_data.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %0d actual %0d", $time,
                   want.inside_res, out_data.inside_res);
          error_count++;
        end
        if (out_data.angle_index !== want.angle_index) begin
          $display("%0t: angle_index expected %0d actual %0d", $time,
                   want.angle_index, out_data.angle_index);
          error_count++;
        end
        if (out_data.radius_index !== want.radius_index) begin
          $display("%0t: radius_index expected %0d actual %0d", $time,
                   want.radius_index, out_data.radius_index);
          error_count++;
        end
      end
    end
  end

  task automatic send_pixel(int unsigned col, int unsigned row);
    c2p_pkg::in_t p;
    int           gap;
    p.column = col[11:0];
    p.row    = row[11:0];
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    pixel_results_q.push_back(map_pixel(p));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold until the pipeline is empty, then let it settle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[c2p_pkg::DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      c2p_pkg::REG_OUT_WIDTH:    width_r  = val[c2p_pkg::DIM_W-1:0];
      c2p_pkg::REG_OUT_HEIGHT:   height_r = val[c2p_pkg::DIM_W-1:0];
      c2p_pkg::REG_ANGLE_COUNT:  angles_r = val[c2p_pkg::DIM_W-1:0];
      c2p_pkg::REG_RADIUS_COUNT: radii_r  = val[c2p_pkg::DIM_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(int unsigned w, int unsigned h, int unsigned ac, int unsigned rc);
    settle();
    write_reg(c2p_pkg::REG_OUT_WIDTH, w);
    write_reg(c2p_pkg::REG_OUT_HEIGHT, h);
    write_reg(c2p_pkg::REG_ANGLE_COUNT, ac);
    write_reg(c2p_pkg::REG_RADIUS_COUNT, rc);
  endtask

  task automatic test_default_corners();
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(256, 256);
    send_pixel(257, 256);
    send_pixel(511, 0);
    send_pixel(0, 511);
    send_pixel(2730, 1365);
  endtask

  // odd sizes put the centre on a pixel: exercise the axis cases
  task automatic test_axis_cases();
    set_sizes(511, 511, 4096, 4096);
    send_pixel(256, 256);
    send_pixel(256, 300);
    send_pixel(256, 10);
    send_pixel(10, 256);
    send_pixel(500, 256);
    send_pixel(511, 256);
    send_pixel(256, 511);
    send_pixel(1, 256);
    send_pixel(0, 256);
  endtask

  task automatic test_size_extremes();
    set_sizes(0, 1, 0, 1);
    write_reg(REG_UNMAPPED, 100);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(2, 1);
    send_pixel(1, 2);
    set_sizes(8191, 8191, 8191, 8191);
    send_pixel(2048, 2048);
    send_pixel(4095, 2048);
    send_pixel(0, 4095);
    send_pixel(1, 1);
  endtask

  task automatic test_random_sweep();
    int unsigned w, h, ac, rc;
    for (int phase = 0; phase < 5; phase++) begin
      w  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 64);
      h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 64);
      ac = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      rc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 4096);
      set_sizes(w, h, ac, rc);
      quiet = (phase == 2);
      w = clamp_dim(width_r, 2);
      h = clamp_dim(height_r, 2);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          send_pixel($urandom_range(0, (w < 4095) ? w : 4095),
                     $urandom_range(0, (h < 4095) ? h : 4095));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    quiet       = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    width_r     = 512;
    height_r    = 512;
    angles_r    = 512;
    radii_r     = 512;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_corners();
    test_axis_cases();
    test_size_extremes();
    test_random_sweep();
    settle();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
